// File: rtl/core/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, round constants, initial chaining values and sigma functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumVars = 8;
  localparam int unsigned NumRnds = 64;

  typedef logic [WordW-1:0] word_t;

  // Working variables a..h, index 0 is a.
  typedef word_t [NumVars-1:0] vars_t;

  localparam word_t H_INIT [NumVars] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [NumRnds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t small_sigma0(word_t v);
    return {v[6:0], v[31:7]} ^ {v[17:0], v[31:18]} ^ {3'b000, v[31:3]};
  endfunction

  function automatic word_t small_sigma1(word_t v);
    return {v[16:0], v[31:17]} ^ {v[18:0], v[31:19]} ^ {10'd0, v[31:10]};
  endfunction

  function automatic word_t big_sigma0(word_t v);
    return {v[1:0], v[31:2]} ^ {v[12:0], v[31:13]} ^ {v[21:0], v[31:22]};
  endfunction

  function automatic word_t big_sigma1(word_t v);
    return {v[5:0], v[31:6]} ^ {v[10:0], v[31:11]} ^ {v[24:0], v[31:25]};
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/sha256_round.sv
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round: next working variables from current ones and W[t].
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_round (
  input  sha256_pkg::vars_t vars_i,
  input  sha256_pkg::word_t wt_i,
  input  logic [5:0]        rnd_i,
  output sha256_pkg::vars_t vars_o
);

  sha256_pkg::word_t choose, major, t1, t2;

  always_comb begin
    choose = (vars_i[4] & vars_i[5]) ^ (~vars_i[4] & vars_i[6]);
    major  = (vars_i[0] & vars_i[1]) ^ (vars_i[0] & vars_i[2]) ^ (vars_i[1] & vars_i[2]);
    t1     = vars_i[7] + sha256_pkg::big_sigma1(vars_i[4]) + choose
           + sha256_pkg::ROUND_K[rnd_i] + wt_i;
    t2     = sha256_pkg::big_sigma0(vars_i[0]) + major;

    vars_o[7] = vars_i[6];
    vars_o[6] = vars_i[5];
    vars_o[5] = vars_i[4];
    vars_o[4] = vars_i[3] + t1;
    vars_o[3] = vars_i[2];
    vars_o[2] = vars_i[1];
    vars_o[1] = vars_i[0];
    vars_o[0] = t1 + t2;
  end

endmodule

`default_nettype wire

// File: rtl/core/sha256_block_compressor.sv
// ----------------------------------------------------------------------------
// SHA-256 block compressor
// Collects 16 message words per block, runs 64 rounds on one shared round
// unit, folds the result into the chaining words and emits the digest.
// ----------------------------------------------------------------------------
// Flow: the 16th word of a block starts the rounds and then the chaining add,
//   paced by the single round unit doing one round per cycle, while the input
//   is held off. A final block holds the input off further, until all eight
//   digest words have entered the output register.
// Output: after a final block's chaining add, the emit state loads H0..H7
//   into the output register, one word per cycle unless the output stalls.
// Reset: chaining words load the standard initial values, word count and
//   sequencer clear; no clearing pass is needed.
`default_nettype none

module sha256_block_compressor (
  input  logic  clk_i,
  input  logic  rst_ni,
  // message word channel
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  logic [31:0] msg_word_i,
  input  logic  start_of_message_i,
  input  logic  end_of_message_i,
  // digest channel
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output logic [31:0] digest_word_o,
  output logic  digest_last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,   // collecting message words
    ST_ROUND,  // 64 rounds on the shared unit
    ST_FINAL,  // add working vars into chaining words
    ST_EMIT    // push H0..H7 through the output register
  } state_e;

  state_e             state_q;
  logic [3:0]         word_cnt_q;
  logic [5:0]         rnd_q;
  logic [2:0]         emit_idx_q;
  logic               fin_q;
  sha256_pkg::word_t  chain_q [8];
  sha256_pkg::vars_t  vars_q;
  sha256_pkg::word_t  win_q [16];
  logic               out_valid_q;
  logic               digest_last_q;
  sha256_pkg::word_t  digest_word_q;

  logic               in_xfer;
  logic               out_free;
  logic [3:0]         word_idx;
  logic               block_done;
  sha256_pkg::word_t  sched_next;
  sha256_pkg::vars_t  vars_next;

  // The block only takes words while collecting; compression and digest
  // output both hold the input side off.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Output register is free when empty or when its word transfers now.
  assign out_free   = !out_valid_q || !out_stall_i;

  // A start flag restarts the block at word zero.
  assign word_idx   = start_of_message_i ? 4'd0 : word_cnt_q;
  assign block_done = (word_idx == 4'hF);

  // Schedule window is a 16-word shift line: win_q[0] is W[t]. The next
  // word W[t+16] is built every round; the extra ones past round 47 are
  // simply never consumed.
  assign sched_next = sha256_pkg::small_sigma1(win_q[14]) + win_q[9]
                    + sha256_pkg::small_sigma0(win_q[1]) + win_q[0];

  sha256_round u_round (
    .vars_i (vars_q),
    .wt_i   (win_q[0]),
    .rnd_i  (rnd_q),
    .vars_o (vars_next)
  );

  // Sequencer, chaining words and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      word_cnt_q    <= '0;
      rnd_q         <= '0;
      emit_idx_q    <= '0;
      fin_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      digest_last_q <= 1'b0;
      digest_word_q <= '0;
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= sha256_pkg::H_INIT[i];
      end
    end else begin
      if (out_free) begin
        out_valid_q   <= (state_q == ST_EMIT);
        digest_word_q <= chain_q[emit_idx_q];
        digest_last_q <= (emit_idx_q == 3'd7);
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            if (start_of_message_i) begin
              for (int i = 0; i < 8; i++) begin
                chain_q[i] <= sha256_pkg::H_INIT[i];
              end
            end
            word_cnt_q <= word_idx + 4'd1;  // wraps to zero after word 15
            if (block_done) begin
              state_q <= ST_ROUND;
              rnd_q   <= '0;
              fin_q   <= end_of_message_i;
            end
          end
        end
        ST_ROUND: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) begin
            state_q <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          for (int i = 0; i < 8; i++) begin
            chain_q[i] <= chain_q[i] + vars_q[i];
          end
          emit_idx_q <= '0;
          state_q    <= fin_q ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (out_free) begin
            emit_idx_q <= emit_idx_q + 3'd1;
            if (emit_idx_q == 3'd7) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath storage: schedule window and working variables.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      win_q[word_idx] <= msg_word_i;
      if (block_done) begin
        for (int i = 0; i < 8; i++) begin
          vars_q[i] <= chain_q[i];
        end
      end
    end else if (state_q == ST_ROUND) begin
      vars_q <= vars_next;
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= sched_next;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign digest_word_o = digest_word_q;
  assign digest_last_o = digest_last_q;

  // Only the final digest word may linger in the output register once the
  // sequencer has left the emit state.
  a_early_words_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !digest_last_o |-> state_q == ST_EMIT)
    else $error("non-final digest word valid outside emit");

  // The sixteenth word of a block launches round zero.
  a_block_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && block_done |=> state_q == ST_ROUND && rnd_q == 6'd0)
    else $error("block did not start compression");

  // Exactly 64 rounds, then the chaining add.
  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROUND && rnd_q == 6'd63 |=> state_q == ST_FINAL)
    else $error("round sequence did not end after 64 rounds");

  // Final block goes on to emit the digest, others return to collecting.
  a_final_branch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINAL |=> (state_q == ST_EMIT) == $past(fin_q))
    else $error("wrong branch after chaining add");

endmodule

`default_nettype wire

// File: test/sha256_digest_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches both channels of the block compressor, keeps its own copy of the
// hash state, predicts every digest word and compares each digest transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] msg_word_i,
  input  logic        start_of_message_i,
  input  logic        end_of_message_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] digest_word_i,
  input  logic        digest_last_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_item_t;

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] CHAIN_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [31:0]  chain [8];
  logic [31:0]  sched [16];
  logic [3:0]   word_pos;
  digest_item_t pending_digest_q [$];
  int unsigned  fail_cnt;
  int unsigned  checked_cnt;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] v);
    return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] v);
    return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] v);
    return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] v);
    return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  // 64 rounds over the collected window, schedule expanded in place
  function automatic void compress_block();
    logic [31:0] v [8];
    logic [31:0] wt, t1, t2, ch, maj;
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = sched[t];
      end else begin
        wt = ssig1(sched[(t - 2) % 16]) + sched[(t - 7) % 16]
           + ssig0(sched[(t - 15) % 16]) + sched[t % 16];
        sched[t % 16] = wt;
      end
      ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
      maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t1  = v[7] + bsig1(v[4]) + ch + ROUND_CONST[t] + wt;
      t2  = bsig0(v[0]) + maj;
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endfunction

  // One accepted message word; queues the digest when a final block closes.
  function automatic void absorb_word(input logic [31:0] word, input logic som,
                                      input logic eom);
    digest_item_t item;
    if (som) begin
      for (int i = 0; i < 8; i++) chain[i] = CHAIN_IV[i];
      word_pos = '0;
    end
    sched[word_pos] = word;
    if (word_pos != 4'd15) begin
      word_pos = word_pos + 4'd1;
    end else begin
      word_pos = '0;
      compress_block();
      if (eom) begin
        for (int i = 0; i < 8; i++) begin
          item.word = chain[i];
          item.last = (i == 7);
          pending_digest_q.push_back(item);
        end
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    digest_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) chain[i] = CHAIN_IV[i];
      for (int i = 0; i < 16; i++) sched[i] = '0;
      word_pos = '0;
      pending_digest_q.delete();
      fail_cnt = 0;
      checked_cnt = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_digest_q.size() == 0) begin
          $error("digest transfer with none expected: digest_word %h digest_last %b",
                 digest_word_i, digest_last_i);
          fail_cnt++;
        end else begin
          want = pending_digest_q.pop_front();
          checked_cnt++;
          if (digest_word_i !== want.word) begin
            $error("digest_word mismatch: expected %h, actual %h", want.word,
                   digest_word_i);
            fail_cnt++;
          end
          if (digest_last_i !== want.last) begin
            $error("digest_last mismatch: expected %b, actual %b", want.last,
                   digest_last_i);
            fail_cnt++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        absorb_word(msg_word_i, start_of_message_i, end_of_message_i);
      end
    end
    fail_count_o <= fail_cnt;
    pending_o    <= pending_digest_q.size();
    checked_o    <= checked_cnt;
  end

endmodule

// File: test/sha256_block_compressor_tb.sv
// ----------------------------------------------------------------------------
// SHA-256 block compressor testbench
// Feeds message words with random gaps, stalls the digest side at
// random, and leaves prediction and comparison to the digest checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_block_compressor_tb;

  localparam int unsigned RANDOM_WORDS = 200;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  // quiet tail, longer than a full block plus the wait for its first digest word
  localparam int unsigned DRAIN_CYCLES = 120;

  logic        clk_i              = 1'b0;
  logic        rst_ni             = 1'b0;
  logic        in_valid           = 1'b0;
  logic        in_stall;
  logic [31:0] msg_word           = '0;
  logic        start_of_message   = 1'b0;
  logic        end_of_message     = 1'b0;
  logic        out_valid;
  logic        out_stall          = 1'b0;
  logic [31:0] digest_word;
  logic        digest_last;

  int unsigned fail_count;
  int unsigned pending_digests;
  int unsigned digests_checked;
  int unsigned words_sent  = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned stall_run   = 0;
  bit          burst       = 1'b0;

  always #5 clk_i = ~clk_i;

  sha256_block_compressor i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .msg_word_i         (msg_word),
    .start_of_message_i (start_of_message),
    .end_of_message_i   (end_of_message),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .digest_word_o      (digest_word),
    .digest_last_o      (digest_last)
  );

  sha256_digest_checker i_digest_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .msg_word_i         (msg_word),
    .start_of_message_i (start_of_message),
    .end_of_message_i   (end_of_message),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .digest_word_i      (digest_word),
    .digest_last_i      (digest_last),
    .fail_count_o       (fail_count),
    .pending_o          (pending_digests),
    .checked_o          (digests_checked)
  );

  // Digest-side backpressure: runs of stall or no stall, mostly short, with
  // the odd long stall and the odd long quiet stretch so that the drain of
  // eight words sees both steady flow and heavy blocking.
  always @(posedge clk_i) begin
    int unsigned pick;
    if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        out_stall <= 1'b0;
        stall_run <= $urandom_range(0, 6);
      end else if (pick < 62) begin
        out_stall <= 1'b0;
        stall_run <= $urandom_range(30, 120);
      end else if (pick < 94) begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(10, 40);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("sha256_block_compressor regression: fail");
      $finish;
    end
  end

  // Mostly random words, with the all-zero and all-one extremes mixed in.
  function automatic logic [31:0] rand_word();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 32'h0000_0000;
    if (pick == 1) return 32'hffff_ffff;
    return $urandom;
  endfunction

  // One transfer on the message channel. Valid stays high between
  // back-to-back words; it only drops when a gap is inserted, so it never
  // sees two nonblocking writes in one time step.
  task automatic send_word(input logic [31:0] word, input logic som, input logic eom);
    int unsigned pick;
    int unsigned gap;
    pick = $urandom_range(0, 99);
    if (burst || pick < 55) gap = 0;
    else if (pick < 90)     gap = $urandom_range(1, 3);
    else                    gap = $urandom_range(8, 40);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid         <= 1'b1;
    msg_word         <= word;
    start_of_message <= som;
    end_of_message   <= eom;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    words_sent++;
  endtask

  // Sixteen random words. A stray end flag on a word other than the last is
  // something the block must ignore, so a few are sprinkled in.
  task automatic send_block(input logic som, input logic eom);
    for (int i = 0; i < 16; i++) begin
      send_word(rand_word(), som && (i == 0),
                (i == 15) ? eom : ($urandom_range(0, 19) == 0));
    end
  endtask

  initial begin
    int unsigned kind;
    int unsigned blocks;
    int unsigned count;
    int unsigned directed_words;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: an aborted message with early end flags (must be ignored),
    // then a restart in mid-block that discards those words, then one full
    // block of all-ones and all-zeros words closed with the end flag.
    burst = 1'b0;
    send_word(32'h0000_0000, 1'b1, 1'b0);
    send_word(32'h0000_0000, 1'b0, 1'b1);
    send_word(32'h0000_0001, 1'b0, 1'b0);
    send_word(32'h8000_0000, 1'b0, 1'b1);
    for (int i = 0; i < 16; i++) begin
      send_word((i < 8) ? 32'hffff_ffff : 32'h0000_0000, i == 0, i == 15);
    end
    directed_words = words_sent;

    // Random: mostly well-formed messages of one to three blocks, plus
    // chaining onto the previous digest without a start, aborted messages
    // and raw noise with random flags.
    while (words_sent < directed_words + RANDOM_WORDS) begin
      burst = ($urandom_range(0, 3) == 0);
      kind  = $urandom_range(0, 99);
      if (kind < 65) begin
        blocks = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
        for (int b = 0; b < blocks; b++) send_block(b == 0, b == blocks - 1);
      end else if (kind < 78) begin
        send_block(1'b0, 1'b1);
      end else if (kind < 90) begin
        count = $urandom_range(1, 14);
        send_word(rand_word(), 1'b1, 1'b0);
        for (int i = 0; i < count; i++) begin
          send_word(rand_word(), 1'b0, $urandom_range(0, 9) == 0);
        end
      end else begin
        count = $urandom_range(1, 20);
        for (int i = 0; i < count; i++) begin
          send_word(rand_word(), $urandom_range(0, 9) == 0, $urandom_range(0, 2) == 0);
        end
      end
    end
    in_valid <= 1'b0;

    // Drain: let the checker's count settle after the last transfer;
    // then all expected digests out, then a quiet tail to catch strays.
    @(posedge clk_i);
    wait (pending_digests == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d message words (%0d directed) with random gaps and stalls",
             words_sent, directed_words);
    $display("checked %0d digest words across full, chained, aborted and noisy messages",
             digests_checked);
    if (fail_count == 0 && pending_digests == 0) begin
      $display("sha256_block_compressor regression: pass");
    end else begin
      $display("sha256_block_compressor regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/sha256_pkg.sv
rtl/core/sha256_round.sv
rtl/core/sha256_block_compressor.sv
test/sha256_digest_checker.sv
test/sha256_block_compressor_tb.sv
